>>> rtl/core/etf_pkg.sv
package etf_pkg;

   localparam int C_W           = 32;
   localparam int LIMIT_W       = 16;
   localparam int COUNT_OUT_W   = 16;
   localparam int MAG_W         = 36;
   localparam int REQ_DATA_W    = 2 * C_W;
   localparam int RSP_DATA_W    = 56;
   localparam int RSP_USER_W    = 2;

   localparam int FRAC_BITS_DEF  = 28;
   localparam int COUNT_BITS_DEF = 16;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd256;

   localparam int QUEUE_DEPTH = 2;

   // point plus the classifier verdict, as it sits in the queue
   typedef struct packed {
      logic signed [C_W-1:0] c_imag;
      logic signed [C_W-1:0] c_real;
      logic                  bulb_hit;
   } item_type;

   typedef struct packed {
      logic [MAG_W-1:0]       magnitude_sq;
      logic                   escaped;
      logic                   bulb_hit;
      logic [COUNT_OUT_W-1:0] count;
   } result_type;

   typedef enum logic {
      ITER_IDLE,
      ITER_RUN
   } iter_state_type;

   // width of z and of the offset values: holds |z| < 4 + |c| with sign
   function automatic int ext_width(input int frac);
      return ((frac + 3 > C_W) ? frac + 3 : C_W) + 1;
   endfunction

endpackage

>>> rtl/core/etf_classify.sv
module etf_classify #(
   parameter int FRAC_BITS = etf_pkg::FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [etf_pkg::REQ_DATA_W-1:0]   req_data,
   output logic                             item_valid,
   input  logic                             item_ready,
   output etf_pkg::item_type                item_data
);
   import etf_pkg::*;

   localparam int XW  = ext_width(FRAC_BITS);
   localparam int PW  = 2 * XW;
   localparam int SW  = PW - FRAC_BITS;
   localparam int QW  = FRAC_BITS + 7;
   localparam int QPW = 2 * QW;

   localparam logic signed [XW-1:0] ONE_X     = XW'(1) << FRAC_BITS;
   localparam logic signed [XW-1:0] QUARTER_X = XW'(1) << (FRAC_BITS - 2);
   localparam logic signed [XW-1:0] FOUR_X    = XW'(1) << (FRAC_BITS + 2);
   localparam logic signed [SW:0]   SIXTEENTH = (SW + 1)'(1) << (FRAC_BITS - 4);

   logic advance;

   logic                  s1_valid_ff;
   logic signed [C_W-1:0] s1_cr_ff, s1_ci_ff;

   logic                  s2_valid_ff;
   logic signed [C_W-1:0] s2_cr_ff, s2_ci_ff;
   logic                  s2_inr_ff;
   logic signed [SW-1:0]  s2_dd_ff, s2_tt_ff, s2_yy_ff;
   logic signed [XW-1:0]  s2_t_ff;

   logic                  s3_valid_ff;
   logic signed [C_W-1:0] s3_cr_ff, s3_ci_ff;
   logic                  s3_inr_ff, s3_hit1_ff;
   logic signed [QW-1:0]  s3_q_ff, s3_qt_ff, s3_yy4_ff;

   // stage 1 -> 2: squares of (c_real + 1), (c_real - 1/4) and c_imag
   logic signed [XW-1:0] cr1, ci1, d1;
   logic signed [PW-1:0] dd_full, tt_full, yy_full;
   logic signed [SW-1:0] dd_in, tt_in, yy_in;
   logic signed [XW-1:0] t_in;
   logic                 inr_in;

   assign cr1  = XW'(s1_cr_ff);
   assign ci1  = XW'(s1_ci_ff);
   assign d1   = cr1 + ONE_X;
   assign t_in = cr1 - QUARTER_X;
   assign inr_in = (cr1 > -FOUR_X) && (cr1 < FOUR_X) && (ci1 > -FOUR_X) && (ci1 < FOUR_X);

   assign dd_full = PW'(d1) * PW'(d1);
   assign tt_full = PW'(t_in) * PW'(t_in);
   assign yy_full = PW'(ci1) * PW'(ci1);
   assign dd_in   = SW'(dd_full >>> FRAC_BITS);
   assign tt_in   = SW'(tt_full >>> FRAC_BITS);
   assign yy_in   = SW'(yy_full >>> FRAC_BITS);

   // stage 2 -> 3: period-2 bulb test, q and q + t for the cardioid
   // (narrowed values are exact whenever the point is in range)
   logic                 hit1_in;
   logic signed [SW-1:0] q_sum;
   logic signed [QW-1:0] q_in, qt_in, yy4_in;

   assign hit1_in = ((SW + 1)'(s2_dd_ff) + (SW + 1)'(s2_yy_ff)) <= SIXTEENTH;
   assign q_sum   = s2_tt_ff + s2_yy_ff;
   assign q_in    = QW'(q_sum);
   assign qt_in   = q_in + QW'(s2_t_ff);
   assign yy4_in  = QW'(s2_yy_ff >>> 2);

   // stage 3 out: cardioid test q*(q+t) <= y^2/4
   logic signed [QPW-1:0] pq_full, pq_shift;
   logic                  hit2;

   assign pq_full  = QPW'(s3_q_ff) * QPW'(s3_qt_ff);
   assign pq_shift = pq_full >>> FRAC_BITS;
   assign hit2     = pq_shift <= QPW'(s3_yy4_ff);

   assign advance    = !s3_valid_ff || item_ready;
   assign req_ready  = advance;
   assign item_valid = s3_valid_ff;

   always_comb begin
      item_data.c_real   = s3_cr_ff;
      item_data.c_imag   = s3_ci_ff;
      item_data.bulb_hit = s3_inr_ff && (s3_hit1_ff || hit2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_cr_ff   <= req_data[C_W-1:0];
         s1_ci_ff   <= req_data[2*C_W-1:C_W];

         s2_cr_ff   <= s1_cr_ff;
         s2_ci_ff   <= s1_ci_ff;
         s2_inr_ff  <= inr_in;
         s2_dd_ff   <= dd_in;
         s2_tt_ff   <= tt_in;
         s2_yy_ff   <= yy_in;
         s2_t_ff    <= t_in;

         s3_cr_ff   <= s2_cr_ff;
         s3_ci_ff   <= s2_ci_ff;
         s3_inr_ff  <= s2_inr_ff;
         s3_hit1_ff <= hit1_in;
         s3_q_ff    <= q_in;
         s3_qt_ff   <= qt_in;
         s3_yy4_ff  <= yy4_in;
      end
   end

endmodule

>>> rtl/core/etf_queue.sv
module etf_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  etf_pkg::item_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output etf_pkg::item_type out_data
);
   import etf_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   item_type           mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]     fill_ff, fill_in;
   logic               push, pop;

   assign in_ready  = fill_ff < (PTR_W + 1)'(QUEUE_DEPTH);
   assign out_valid = fill_ff != '0;
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   fill_in = fill_ff + 1'b1;
         2'b01:   fill_in = fill_ff - 1'b1;
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

>>> rtl/core/etf_iter.sv
module etf_iter #(
   parameter int FRAC_BITS  = etf_pkg::FRAC_BITS_DEF,
   parameter int COUNT_BITS = etf_pkg::COUNT_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         item_valid,
   output logic                         item_ready,
   input  etf_pkg::item_type            item_data,
   input  logic [etf_pkg::LIMIT_W-1:0]  limit,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output etf_pkg::result_type          rsp_data
);
   import etf_pkg::*;

   localparam int XW = ext_width(FRAC_BITS);
   localparam int PW = 2 * XW;
   localparam int LW = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;

   localparam logic signed [PW-1:0]   FOUR_P = PW'(1) << (FRAC_BITS + 2);
   localparam logic [COUNT_BITS-1:0]  CMAX   = '1;

   iter_state_type          state_ff, state_in;
   logic signed [XW-1:0]    x_ff, x_in, y_ff, y_in;
   logic signed [XW-1:0]    cr_ff, cr_in, ci_ff, ci_in;
   logic [COUNT_BITS-1:0]   count_ff, count_in;
   logic [COUNT_BITS-1:0]   limit_ff, limit_in;
   logic [MAG_W-1:0]        mag_ff, mag_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   result_type              rsp_ff, rsp_in;

   // one iteration of z = z^2 + c
   logic signed [PW-1:0]    xx_full, yy_full, xy_full;
   logic signed [PW-1:0]    x2, y2, xy, sum;
   logic signed [XW-1:0]    nx, ny;
   logic [MAG_W-1:0]        mag_sat;
   logic                    limit_hit, escape, slot_free;
   logic [LW-1:0]           lim_ext;
   logic [COUNT_BITS-1:0]   lim_clamped;

   assign xx_full = PW'(x_ff) * PW'(x_ff);
   assign yy_full = PW'(y_ff) * PW'(y_ff);
   assign xy_full = PW'(x_ff) * PW'(y_ff);
   assign x2      = xx_full >>> FRAC_BITS;
   assign y2      = yy_full >>> FRAC_BITS;
   assign xy      = xy_full >>> FRAC_BITS;
   assign sum     = x2 + y2;
   assign nx      = XW'(x2 - y2 + PW'(cr_ff));
   assign ny      = XW'((xy <<< 1) + PW'(ci_ff));
   assign mag_sat = (|sum[PW-1:MAG_W]) ? '1 : sum[MAG_W-1:0];

   assign limit_hit = count_ff >= limit_ff;
   assign escape    = !limit_hit && (sum >= FOUR_P);
   assign slot_free = !rsp_valid_ff || rsp_ready;

   assign lim_ext     = LW'(limit);
   assign lim_clamped = (lim_ext > LW'(CMAX)) ? CMAX : COUNT_BITS'(lim_ext);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      cr_in        = cr_ff;
      ci_in        = ci_ff;
      count_in     = count_ff;
      limit_in     = limit_ff;
      mag_in       = mag_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      item_ready   = 1'b0;

      unique case (state_ff)
         ITER_IDLE: begin
            // a bulb hit finishes here and needs the output slot
            item_ready = !item_data.bulb_hit || slot_free;
            if (item_valid && item_ready) begin
               if (item_data.bulb_hit) begin
                  rsp_valid_in        = 1'b1;
                  rsp_in.count        = '0;
                  rsp_in.bulb_hit     = 1'b1;
                  rsp_in.escaped      = 1'b0;
                  rsp_in.magnitude_sq = '0;
               end else begin
                  x_in     = XW'(item_data.c_real);
                  y_in     = XW'(item_data.c_imag);
                  cr_in    = XW'(item_data.c_real);
                  ci_in    = XW'(item_data.c_imag);
                  count_in = COUNT_BITS'(1);
                  limit_in = lim_clamped;
                  mag_in   = '0;
                  state_in = ITER_RUN;
               end
            end
         end
         ITER_RUN: begin
            if (limit_hit || escape) begin
               if (slot_free) begin
                  rsp_valid_in        = 1'b1;
                  rsp_in.count        = COUNT_OUT_W'(count_ff);
                  rsp_in.bulb_hit     = 1'b0;
                  rsp_in.escaped      = escape;
                  rsp_in.magnitude_sq = escape ? mag_sat : mag_ff;
                  state_in            = ITER_IDLE;
               end
            end else begin
               x_in     = nx;
               y_in     = ny;
               mag_in   = mag_sat;
               count_in = count_ff + 1'b1;
            end
         end
         default: begin
            state_in = ITER_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ITER_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      y_ff     <= y_in;
      cr_ff    <= cr_in;
      ci_ff    <= ci_in;
      count_ff <= count_in;
      limit_ff <= limit_in;
      mag_ff   <= mag_in;
      rsp_ff   <= rsp_in;
   end

endmodule

>>> rtl/core/escape_time_fractal_iterator.sv
// Mandelbrot escape-time unit. Each req item carries a point c in signed
// fixed point (FRAC_BITS fraction bits) and gives exactly one rsp item. A
// three-stage classifier first tests c against the main cardioid and the
// period-2 bulb. Every point then passes a two-entry queue to the
// iteration unit. A bulb hit leaves there at once with count 0 and
// bulb_hit set. Other points run z = z*z + c from z = c at one iteration
// per clock on three parallel multipliers, until |z|^2 reaches 4 or the
// count reaches the iteration limit (csr_data, reset 256, values above
// 2^COUNT_BITS-1 are clamped). The iteration unit works on one point at a
// time and takes the next only once the last has finished and its result
// has found room in the output register, so a low rsp_tready holds it too.
// That unit sets the throughput. Write the limit only while no items are in
// flight.
module escape_time_fractal_iterator #(
   parameter int FRAC_BITS  = etf_pkg::FRAC_BITS_DEF,
   parameter int COUNT_BITS = etf_pkg::COUNT_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // c_real[31:0], c_imag[63:32]
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [etf_pkg::REQ_DATA_W-1:0]   req_tdata,
   // iteration_count[15:0], final_magnitude_sq[51:16], zero pad above
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [etf_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // bulb_hit[0], escaped[1]
   output logic [etf_pkg::RSP_USER_W-1:0]   rsp_tuser,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [etf_pkg::LIMIT_W-1:0]      csr_data
);
   import etf_pkg::*;

   localparam int PAD_W = RSP_DATA_W - MAG_W - COUNT_OUT_W;

   logic [LIMIT_W-1:0] limit_ff;

   logic       cls_valid, cls_ready;
   item_type   cls_data;
   logic       q_valid, q_ready;
   item_type   q_data;
   result_type result;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         limit_ff <= csr_data;
      end
   end

   etf_classify #(
      .FRAC_BITS (FRAC_BITS)
   ) u_classify (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_data   (req_tdata),
      .item_valid (cls_valid),
      .item_ready (cls_ready),
      .item_data  (cls_data)
   );

   etf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cls_valid),
      .in_ready  (cls_ready),
      .in_data   (cls_data),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_data  (q_data)
   );

   etf_iter #(
      .FRAC_BITS  (FRAC_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_iter (
      .clock      (clock),
      .reset      (reset),
      .item_valid (q_valid),
      .item_ready (q_ready),
      .item_data  (q_data),
      .limit      (limit_ff),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_data   (result)
   );

   assign rsp_tdata = {{PAD_W{1'b0}}, result.magnitude_sq, result.count};
   assign rsp_tuser = {result.escaped, result.bulb_hit};

endmodule

>>> verif/escape_outcome_checker.sv
module escape_outcome_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   // c_real[31:0], c_imag[63:32]
   input  logic [etf_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // iteration_count[15:0], final_magnitude_sq[51:16], zero pad above
   input  logic [etf_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // bulb_hit[0], escaped[1]
   input  logic [etf_pkg::RSP_USER_W-1:0] rsp_tuser,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [etf_pkg::LIMIT_W-1:0]    csr_data,
   output int                             mismatches,
   output int                             outstanding
);

   localparam int     FRAC      = etf_pkg::FRAC_BITS_DEF;
   localparam int     COUNT_W   = etf_pkg::COUNT_BITS_DEF;
   localparam longint ONE       = longint'(1) <<< FRAC;
   localparam longint QUARTER   = ONE >>> 2;
   localparam longint SIXTEENTH = ONE >>> 4;
   localparam longint FOUR      = ONE * 4;
   localparam longint MAG_SAT   = (longint'(1) <<< etf_pkg::MAG_W) - 1;

   typedef struct packed {
      logic [etf_pkg::COUNT_OUT_W-1:0] count;
      logic                            bulb_hit;
      logic                            escaped;
      logic [etf_pkg::MAG_W-1:0]       mag_sq;
   } escape_outcome_type;

   escape_outcome_type          expected_outcomes[$];
   logic [etf_pkg::LIMIT_W-1:0] iter_limit;
   int                          miss_count = 0;

   assign mismatches = miss_count;

   // exact product, then floor shift by the fraction width
   function automatic longint scaled_product(input longint a, input longint b);
      logic signed [127:0] full;
      full = a;
      full = full * b;
      return longint'(full >>> FRAC);
   endfunction

   function automatic escape_outcome_type predict_escape(input logic signed [31:0] re,
                                                         input logic signed [31:0] im,
                                                         input logic [etf_pkg::LIMIT_W-1:0] lim);
      longint             cr, ci, x, y, x2, y2, yy, d, t, q, nx, mag;
      int                 count, cap;
      logic               esc, hit;
      escape_outcome_type res;
      cr  = re;
      ci  = im;
      cap = lim;
      if (cap > (1 << COUNT_W) - 1) cap = (1 << COUNT_W) - 1;
      x2  = 0;
      y2  = 0;
      esc = 1'b0;
      res = '0;
      // neither region reaches |re| or |im| of 4
      if (cr > -FOUR && cr < FOUR && ci > -FOUR && ci < FOUR) begin
         yy  = scaled_product(ci, ci);
         d   = cr + ONE;
         t   = cr - QUARTER;
         hit = (scaled_product(d, d) + yy <= SIXTEENTH);
         q   = scaled_product(t, t) + yy;
         if (scaled_product(q, q + t) <= (yy >>> 2)) hit = 1'b1;
         if (hit) begin
            res.bulb_hit = 1'b1;
            return res;
         end
      end
      x = cr;
      y = ci;
      for (count = 1; count < cap; count++) begin
         x2 = scaled_product(x, x);
         y2 = scaled_product(y, y);
         nx = x2 - y2 + cr;
         y  = scaled_product(x, y) * 2 + ci;
         x  = nx;
         if (x2 + y2 >= FOUR) begin
            esc = 1'b1;
            break;
         end
      end
      mag = x2 + y2;
      if (mag > MAG_SAT) mag = MAG_SAT;
      res.count   = count[etf_pkg::COUNT_OUT_W-1:0];
      res.escaped = esc;
      res.mag_sq  = mag[etf_pkg::MAG_W-1:0];
      return res;
   endfunction

   always @(posedge clock) begin : watch
      escape_outcome_type want, got;
      if (reset) begin
         expected_outcomes.delete();
         iter_limit  <= etf_pkg::LIMIT_RESET;
         outstanding <= 0;
      end else begin
         // result first: an item taken at this edge cannot have produced it
         if (rsp_tvalid && rsp_tready) begin
            got.count    = rsp_tdata[15:0];
            got.mag_sq   = rsp_tdata[51:16];
            got.bulb_hit = rsp_tuser[0];
            got.escaped  = rsp_tuser[1];
            if (expected_outcomes.size() == 0) begin
               miss_count++;
               if (miss_count <= 10)
                  $display("unexpected result: count %0d bulb %0b esc %0b mag %h",
                           got.count, got.bulb_hit, got.escaped, got.mag_sq);
            end else begin
               want = expected_outcomes.pop_front();
               if (want.count !== got.count || want.bulb_hit !== got.bulb_hit ||
                   want.escaped !== got.escaped || want.mag_sq !== got.mag_sq) begin
                  miss_count++;
                  if (miss_count <= 10)
                     $display({"mismatch (exp/act): count %0d/%0d bulb %0b/%0b",
                               " esc %0b/%0b mag %h/%h"},
                              want.count, got.count, want.bulb_hit, got.bulb_hit,
                              want.escaped, got.escaped, want.mag_sq, got.mag_sq);
               end
            end
         end
         if (req_tvalid && req_tready)
            expected_outcomes.push_back(predict_escape(req_tdata[31:0], req_tdata[63:32],
                                                       iter_limit));
         if (csr_valid && csr_ready) iter_limit <= csr_data;
         outstanding <= expected_outcomes.size();
      end
   end

endmodule

>>> verif/escape_time_fractal_iterator_tb.sv
module escape_time_fractal_iterator_tb;

   localparam int Q = 1 << 28;

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [etf_pkg::REQ_DATA_W-1:0] req_tdata;
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic [etf_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [etf_pkg::RSP_USER_W-1:0] rsp_tuser;
   logic                           csr_valid;
   logic                           csr_ready;
   logic [etf_pkg::LIMIT_W-1:0]    csr_data;
   int                             mismatches;
   int                             outstanding;
   int                             send_idle_pct = 23;
   int                             recv_idle_pct = 63;

   escape_time_fractal_iterator DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   escape_outcome_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // called and returns at a falling edge
   task automatic send_point(input logic [31:0] cr, input logic [31:0] ci);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {ci, cr};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_limit(input logic [etf_pkg::LIMIT_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [31:0] corner_value(input int idx);
      case (idx)
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h4000_0000;
         3:       return 32'hC000_0000;
         4:       return 32'h3FFF_FFFF;
         5:       return 32'hC000_0001;
         default: return 32'h0000_0000;
      endcase
   endfunction

   // mostly points near the set, where the iteration runs long
   function automatic logic [63:0] random_point();
      int          pick;
      logic [31:0] cr, ci;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         cr = $urandom_range(0, 3 * Q) - 9 * (Q / 4);
         ci = $urandom_range(0, 3 * Q) - (3 * Q / 2);
      end else if (pick < 80) begin
         // seahorse valley, slow escapes
         cr = -(3 * Q / 4) + $urandom_range(0, Q / 16) - Q / 32;
         ci = $urandom_range(0, Q / 4) - Q / 8;
      end else if (pick < 95) begin
         cr = $urandom;
         ci = $urandom;
      end else begin
         cr = corner_value($urandom_range(0, 6));
         ci = corner_value($urandom_range(0, 6));
      end
      return {ci, cr};
   endfunction

   initial begin
      int           seg_limits[9];
      logic [63:0]  p;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      csr_valid  = 1'b0;
      csr_data   = '0;
      seg_limits = '{1, 300, 0, 2, 256, 0, 8, 100, 0};
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed, reset limit of 256
      send_point(32'd0, 32'd0);
      send_point(-Q, 32'd0);
      send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_point(32'h8000_0000, 32'h8000_0000);
      send_point(32'h7FFF_FFFF, 32'h8000_0000);
      send_point(32'h4000_0000, 32'd0);
      send_point(32'hC000_0000, 32'd0);
      send_point(32'h3FFF_FFFF, 32'hC000_0001);
      send_point(-2 * Q, 32'd0);
      send_point(Q / 4, 32'd0);
      send_point(Q / 4 + 1, 32'd0);
      send_point(-(3 * Q / 4), Q / 10);
      send_point(-(7 * Q / 4), 32'd0);
      send_point(-32'sd32899718, 32'sd199947370);
      send_point(32'd0, Q);
      send_point(3 * Q / 10, Q / 2);
      send_point(-(5 * Q / 4), 32'd0);
      send_point(-(3 * Q / 4), 32'd0);
      send_point(Q, 32'd0);
      send_point(32'd0, -(Q / 2));
      drain();

      // limits of zero and one never enter the loop
      write_limit(16'd0);
      send_point(Q / 2, Q / 2);
      drain();
      write_limit(16'd1);
      send_point(-(7 * Q / 4), 32'd0);
      drain();
      write_limit(16'hFFFF);
      send_point(-32'sd32899718, 32'sd199947370);
      send_point(32'd0, 32'd0);
      send_point(3 * Q / 10, Q / 2);
      drain();

      for (int seg = 0; seg < 9; seg++) begin
         case (seg / 3)
            0: begin send_idle_pct = 23; recv_idle_pct = 63; end
            1: begin send_idle_pct = 63; recv_idle_pct = 23; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         write_limit((seg % 3 == 2) ? 16'($urandom_range(1, 300)) : 16'(seg_limits[seg]));
         repeat (111) begin
            p = random_point();
            send_point(p[31:0], p[63:32]);
         end
         drain();
      end

      if (mismatches == 0)
         $display("escape_time_fractal_iterator regression: pass");
      else
         $display("escape_time_fractal_iterator regression: fail");
      $finish;
   end

   initial begin
      #30_000_000;
      $display("escape_time_fractal_iterator regression: fail");
      $finish;
   end

endmodule

>>> files.f
rtl/core/etf_pkg.sv
rtl/core/etf_classify.sv
rtl/core/etf_queue.sv
rtl/core/etf_iter.sv
rtl/core/escape_time_fractal_iterator.sv
verif/escape_outcome_checker.sv
verif/escape_time_fractal_iterator_tb.sv
